// ----- rtl/blmd_pkg.sv -----
// blmd_pkg: shared types and constants of the BER length message deframer
// used by blmd_apb_regs, blmd_core and ber_length_message_deframer_unit; no dependencies
package blmd_pkg;

    localparam int unsigned APB_ADDR_W = 3;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_SYNC_WORD      = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_IGNORED_METHOD = 3'd4;

    localparam logic [31:0] SYNC_WORD_RESET      = 32'h7b02342b;
    localparam logic [7:0]  IGNORED_METHOD_RESET = 8'd6;

    // BER lead bytes that announce one, two or three length bytes
    localparam logic [7:0] BER_LEAD_LEN1 = 8'h81;
    localparam logic [7:0] BER_LEAD_LEN3 = 8'h83;
    localparam logic [7:0] BER_LEAD_BASE = 8'h80;

    // header byte positions, counted from the first sync byte
    localparam logic [4:0] SYNC_BYTES      = 5'd4;
    localparam logic [4:0] HDR_METHOD      = 5'd6;
    localparam logic [4:0] HDR_OBJECT_LO   = 5'd7;
    localparam logic [4:0] HDR_OBJECT_HI   = 5'd8;
    localparam logic [4:0] HDR_ERROR_LO    = 5'd9;
    localparam logic [4:0] HDR_ERROR_HI    = 5'd10;

    typedef struct packed {
        logic [7:0]  param_byte;
        logic        byte_valid;
        logic [23:0] param_offset;
        logic [7:0]  method_code;
        logic [15:0] object_id;
        logic [15:0] error_code;
        logic        device_error;
        logic        last;
        logic        sync_lost;
    } result_t;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [7:0]  ignored_method;
    } cfg_t;

endpackage

// ----- rtl/ber_length_message_deframer_unit.sv -----
// ber_length_message_deframer_unit: top level, input register, result register
// depends on blmd_pkg, blmd_apb_regs and blmd_core
//
// Takes one received byte per transfer and sustains one byte per clock cycle
// unless a result waits for m_ready. A byte lands in the input register and
// is decoded by the deframer state machine once the result register is free;
// its result, if any, is loaded into the result register at the end of that
// cycle. While a result waits for m_ready, the input register holds one more
// byte and then s_ready drops. Each byte gives at most one result: a parameter
// byte with the header fields, an empty-message marker or a sync_lost flag.
// Messages whose method equals ignored_method give no results. The sync word
// and ignored method are set over the APB port, at byte addresses 0 and 4; the
// user must set them only while the block is idle, which it does not enforce.
module ber_length_message_deframer_unit #(
    parameter int unsigned HEADER_BYTES = 18
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [blmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_param_byte,
    output logic                            m_byte_valid,
    output logic [23:0]                     m_param_offset,
    output logic [7:0]                      m_method_code,
    output logic [15:0]                     m_object_id,
    output logic [15:0]                     m_error_code,
    output logic                            m_device_error,
    output logic                            m_last,
    output logic                            m_sync_lost
);
    import blmd_pkg::*;

    cfg_t        cfg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic        out_free;
    logic        step;
    logic        res_valid;
    result_t     res;

    blmd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blmd_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // result register reloads whenever it is empty or its transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid && out_free) begin
            out_res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_param_byte   = out_res_reg.param_byte;
    assign m_byte_valid   = out_res_reg.byte_valid;
    assign m_param_offset = out_res_reg.param_offset;
    assign m_method_code  = out_res_reg.method_code;
    assign m_object_id    = out_res_reg.object_id;
    assign m_error_code   = out_res_reg.error_code;
    assign m_device_error = out_res_reg.device_error;
    assign m_last         = out_res_reg.last;
    assign m_sync_lost    = out_res_reg.sync_lost;

endmodule

// ----- rtl/blmd_apb_regs.sv -----
// blmd_apb_regs: APB configuration registers (sync word, ignored method)
// depends on blmd_pkg
module blmd_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [blmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output blmd_pkg::cfg_t                  cfg
);
    import blmd_pkg::*;

    logic [31:0] sync_word_reg;
    logic [7:0]  ignored_method_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // decode on the word address bit; byte lane bits only gate the read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg      <= SYNC_WORD_RESET;
            ignored_method_reg <= IGNORED_METHOD_RESET;
        end else if (wr_en) begin
            if (paddr[2] == ADDR_IGNORED_METHOD[2]) begin
                ignored_method_reg <= pwdata[7:0];
            end else begin
                sync_word_reg <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'd0) begin
            if (paddr[2] == ADDR_IGNORED_METHOD[2]) begin
                prdata = {24'd0, ignored_method_reg};
            end else begin
                prdata = sync_word_reg;
            end
        end
    end

    assign cfg.sync_word      = sync_word_reg;
    assign cfg.ignored_method = ignored_method_reg;

endmodule

// ----- rtl/blmd_core.sv -----
// blmd_core: deframer state machine, one received byte per transfer
// depends on blmd_pkg; result is combinational and registered by the top level
module blmd_core #(
    parameter int unsigned HEADER_BYTES = 18
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  blmd_pkg::cfg_t    cfg,
    output logic              res_valid,
    output blmd_pkg::result_t res
);
    import blmd_pkg::*;

    localparam logic [4:0] LAST_HDR_IDX = 5'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_LEAD,
        PH_LENGTH,
        PH_PARAMS
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  method_reg, method_next;
    logic [15:0] object_reg, object_next;
    logic [15:0] error_reg, error_next;
    logic [1:0]  len_left_reg, len_left_next;
    logic [23:0] len_accum_reg, len_accum_next;
    logic [23:0] done_reg, done_next;

    logic        ignored;
    logic [7:0]  want;
    logic [23:0] off_plus1;
    logic [23:0] len_val;
    logic        len_done;

    assign ignored   = (method_reg == cfg.ignored_method);
    assign off_plus1 = done_reg + 24'd1;

    always_comb begin
        case (hdr_idx_reg[1:0])
            2'd0:    want = cfg.sync_word[31:24];
            2'd1:    want = cfg.sync_word[23:16];
            2'd2:    want = cfg.sync_word[15:8];
            default: want = cfg.sync_word[7:0];
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        method_next    = method_reg;
        object_next    = object_reg;
        error_next     = error_reg;
        len_left_next  = len_left_reg;
        len_accum_next = len_accum_reg;
        done_next      = done_reg;
        len_val        = 24'd0;
        len_done       = 1'b0;

        res_valid        = 1'b0;
        res.param_byte   = 8'd0;
        res.byte_valid   = 1'b0;
        res.param_offset = 24'd0;
        res.method_code  = method_reg;
        res.object_id    = object_reg;
        res.error_code   = error_reg;
        res.device_error = (error_reg != 16'd0);
        res.last         = 1'b0;
        res.sync_lost    = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                case (hdr_idx_reg)
                    HDR_METHOD:    method_next       = rx_byte;
                    HDR_OBJECT_LO: object_next[7:0]  = rx_byte;
                    HDR_OBJECT_HI: object_next[15:8] = rx_byte;
                    HDR_ERROR_LO:  error_next[7:0]   = rx_byte;
                    HDR_ERROR_HI:  error_next[15:8]  = rx_byte;
                    default: ;
                endcase
                if (hdr_idx_reg >= LAST_HDR_IDX) begin
                    phase_next   = PH_LEAD;
                    hdr_idx_next = 5'd0;
                end else begin
                    hdr_idx_next = hdr_idx_reg + 5'd1;
                end
            end

            PH_LEAD: begin
                if (rx_byte >= BER_LEAD_LEN1 && rx_byte <= BER_LEAD_LEN3) begin
                    len_accum_next = 24'd0;
                    len_left_next  = 2'(rx_byte - BER_LEAD_BASE);
                    phase_next     = PH_LENGTH;
                end else begin
                    len_left_next = 2'd0;
                    len_val       = {16'd0, rx_byte};
                    len_done      = 1'b1;
                end
            end

            PH_LENGTH: begin
                len_left_next = len_left_reg - 2'd1;
                len_val       = {len_accum_reg[15:0], rx_byte};
                len_accum_next = len_val;
                len_done      = (len_left_next == 2'd0);
            end

            PH_PARAMS: begin
                done_next        = off_plus1;
                res.param_byte   = rx_byte;
                res.byte_valid   = 1'b1;
                res.param_offset = done_reg;
                res.last         = (off_plus1 == len_accum_reg);
                res_valid        = !ignored;
                if (res.last) begin
                    phase_next   = PH_HUNT;
                    hdr_idx_next = 5'd0;
                end
            end

            default: begin
                if (rx_byte != want) begin
                    hdr_idx_next     = 5'd0;
                    res_valid        = 1'b1;
                    res.method_code  = 8'd0;
                    res.object_id    = 16'd0;
                    res.error_code   = 16'd0;
                    res.device_error = 1'b0;
                    res.sync_lost    = 1'b1;
                end else begin
                    hdr_idx_next = {3'd0, hdr_idx_reg[1:0]} + 5'd1;
                    if (hdr_idx_next == SYNC_BYTES) begin
                        phase_next = PH_HEADER;
                    end
                end
            end
        endcase

        // length known: open the parameters or close an empty message
        if (len_done) begin
            len_accum_next = len_val;
            done_next      = 24'd0;
            if (len_val != 24'd0) begin
                phase_next = PH_PARAMS;
            end else begin
                phase_next   = PH_HUNT;
                hdr_idx_next = 5'd0;
                res.last     = 1'b1;
                res_valid    = !ignored;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            hdr_idx_reg   <= 5'd0;
            method_reg    <= 8'd0;
            object_reg    <= 16'd0;
            error_reg     <= 16'd0;
            len_left_reg  <= 2'd0;
            len_accum_reg <= 24'd0;
            done_reg      <= 24'd0;
        end else if (step) begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            method_reg    <= method_next;
            object_reg    <= object_next;
            error_reg     <= error_next;
            len_left_reg  <= len_left_next;
            len_accum_reg <= len_accum_next;
            done_reg      <= done_next;
        end
    end

endmodule
